[sv/gobs_pkg.sv]
// ----------------------------------------------------------------------------
// Greedy overlap box suppression: shared package
// Beat types, the stored box layout and the microcode table of the sequencer.
// ----------------------------------------------------------------------------
package gobs_pkg;

    localparam int COORD_BITS    = 12;
    localparam int MAX_BOXES_DEF = 64;
    localparam int PROD_W        = 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } box_t;

    typedef struct packed {
        coord_t box_x;
        coord_t box_y;
        coord_t box_width;
        coord_t box_height;
        logic   first_of_list;
    } in_beat_t;

    typedef struct packed {
        logic keep;
        logic store_full;
    } out_beat_t;

    // Microcode steps.
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_LOOP   = 3'd1;
    localparam step_t STEP_LOAD   = 3'd2;
    localparam step_t STEP_MUL    = 3'd3;
    localparam step_t STEP_TEST   = 3'd4;
    localparam step_t STEP_DECIDE = 3'd5;

    // Jump conditions.
    typedef logic [2:0] cond_t;

    localparam cond_t COND_NEVER = 3'd0;
    localparam cond_t COND_NO_IN = 3'd1;
    localparam cond_t COND_END   = 3'd2;
    localparam cond_t COND_HIT   = 3'd3;
    localparam cond_t COND_BUSY  = 3'd4;

    // Datapath actions.
    typedef logic [2:0] act_t;

    localparam act_t ACT_NONE   = 3'd0;
    localparam act_t ACT_LOAD   = 3'd1;
    localparam act_t ACT_READ   = 3'd2;
    localparam act_t ACT_BOUNDS = 3'd3;
    localparam act_t ACT_MUL    = 3'd4;
    localparam act_t ACT_TEST   = 3'd5;
    localparam act_t ACT_FINISH = 3'd6;

    typedef struct packed {
        step_t next_t;
        step_t next_f;
        cond_t cond;
        act_t  act;
    } ucode_t;

    // The next step is next_t when the condition holds, else next_f.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t uc;
        begin
            case (step)
                STEP_IDLE:   uc = '{STEP_IDLE,   STEP_LOOP, COND_NO_IN, ACT_LOAD};
                STEP_LOOP:   uc = '{STEP_DECIDE, STEP_LOAD, COND_END,   ACT_READ};
                STEP_LOAD:   uc = '{STEP_MUL,    STEP_MUL,  COND_NEVER, ACT_BOUNDS};
                STEP_MUL:    uc = '{STEP_TEST,   STEP_TEST, COND_NEVER, ACT_MUL};
                STEP_TEST:   uc = '{STEP_DECIDE, STEP_LOOP, COND_HIT,   ACT_TEST};
                STEP_DECIDE: uc = '{STEP_DECIDE, STEP_IDLE, COND_BUSY,  ACT_FINISH};
                default:     uc = '{STEP_IDLE,   STEP_IDLE, COND_NEVER, ACT_NONE};
            endcase
            return uc;
        end
    endfunction

endpackage

[sv/greedy_overlap_box_suppression.sv]
// ----------------------------------------------------------------------------
// Greedy overlap box suppression
// Judges each rectangle against the survivors of the current list and keeps
// it unless a survivor covers at least 0.4 of its own area with the overlap.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   in_beat_t  (box, first_of_list)
//  m_       out        m_valid / m_ready   out_beat_t (keep, store_full)
//
// A box is checked against each survivor in turn; the scan stops at the first
// survivor that suppresses it. Each survivor passes through the read, bounds,
// multiply and test steps.
// A new beat is taken only in the idle step; the result register holds one
// finished beat, and the sequencer waits in its decide step while it is full.
// Reset empties the survivor list; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module greedy_overlap_box_suppression #(
    parameter int MAX_BOXES = gobs_pkg::MAX_BOXES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gobs_pkg::in_beat_t  s_beat,
    output logic                m_valid,
    input  logic                m_ready,
    output gobs_pkg::out_beat_t m_beat
);

    import gobs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W = $clog2(MAX_BOXES);
    localparam int EDGE_W = COORD_BITS + 1;
    localparam int CMP_W  = PROD_W + 3;

    step_t            upc_reg, upc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             keep_reg, keep_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_beat_reg, m_beat_next;

    box_t              cand_reg, cand_next;
    coord_t            cols_reg, cols_next;
    coord_t            rows_reg, rows_next;
    logic [PROD_W-1:0] area_reg, area_next;
    logic [PROD_W-1:0] inter_reg, inter_next;
    logic              skip_reg, skip_next;
    logic              skip_mul_reg, skip_mul_next;

    ucode_t uc;
    logic   cond_true;
    logic   at_end;
    logic   hit;
    logic   busy;

    logic   ram_we;
    logic   ram_re;
    box_t   ram_rdata;

    box_t              surv;
    logic [EDGE_W-1:0] s_right, s_bot, c_right, c_bot;
    logic [EDGE_W-1:0] lo_x, lo_y, hi_x, hi_y;
    logic              apart;
    logic [CMP_W-1:0]  inter5, area2;

    gobs_ram #(
        .WIDTH ($bits(box_t)),
        .DEPTH (MAX_BOXES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (cand_reg),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s_ready = (upc_reg == STEP_IDLE);
    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    assign at_end = (idx_reg == count_reg);
    assign busy   = m_valid_reg && !m_ready;
    assign inter5 = CMP_W'({inter_reg, 2'b00}) + CMP_W'(inter_reg);
    assign area2  = CMP_W'({area_reg, 1'b0});
    assign hit    = !skip_mul_reg && (inter5 >= area2);

    // Overlap geometry of the survivor just read against the candidate.
    assign surv    = ram_rdata;
    assign s_right = EDGE_W'(surv.x) + EDGE_W'(surv.w);
    assign s_bot   = EDGE_W'(surv.y) + EDGE_W'(surv.h);
    assign c_right = EDGE_W'(cand_reg.x) + EDGE_W'(cand_reg.w);
    assign c_bot   = EDGE_W'(cand_reg.y) + EDGE_W'(cand_reg.h);
    assign lo_x    = (surv.x > cand_reg.x) ? EDGE_W'(surv.x) : EDGE_W'(cand_reg.x);
    assign lo_y    = (surv.y > cand_reg.y) ? EDGE_W'(surv.y) : EDGE_W'(cand_reg.y);
    assign hi_x    = (s_right < c_right) ? s_right : c_right;
    assign hi_y    = (s_bot < c_bot) ? s_bot : c_bot;
    assign apart   = (EDGE_W'(surv.x) > c_right) || (EDGE_W'(surv.y) > c_bot)
                  || (s_right < EDGE_W'(cand_reg.x)) || (s_bot < EDGE_W'(cand_reg.y));

    always_comb begin
        uc = ucode_rom(upc_reg);

        case (uc.cond)
            COND_NEVER: cond_true = 1'b0;
            COND_NO_IN: cond_true = !s_valid;
            COND_END:   cond_true = at_end;
            COND_HIT:   cond_true = hit;
            COND_BUSY:  cond_true = busy;
            default:    cond_true = 1'b0;
        endcase
        upc_next = cond_true ? uc.next_t : uc.next_f;

        count_next    = count_reg;
        idx_next      = idx_reg;
        keep_next     = keep_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_beat_next   = m_beat_reg;
        cand_next     = cand_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        area_next     = area_reg;
        inter_next    = inter_reg;
        skip_next     = skip_reg;
        skip_mul_next = skip_mul_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        case (uc.act)
            ACT_LOAD: begin
                if (s_valid) begin
                    cand_next = '{s_beat.box_x, s_beat.box_y,
                                  s_beat.box_width, s_beat.box_height};
                    keep_next = 1'b1;
                    idx_next  = '0;
                    if (s_beat.first_of_list) begin
                        count_next = '0;
                    end
                end
            end
            ACT_READ: begin
                ram_re = !at_end;
            end
            ACT_BOUNDS: begin
                cols_next = COORD_BITS'(hi_x - lo_x);
                rows_next = COORD_BITS'(hi_y - lo_y);
                area_next = PROD_W'(surv.w) * PROD_W'(surv.h);
                skip_next = apart || (surv.w == '0) || (surv.h == '0);
                idx_next  = idx_reg + CNT_W'(1);
            end
            ACT_MUL: begin
                inter_next    = PROD_W'(cols_reg) * PROD_W'(rows_reg);
                skip_mul_next = skip_reg;
            end
            ACT_TEST: begin
                if (hit) begin
                    keep_next = 1'b0;
                end
            end
            ACT_FINISH: begin
                if (!busy) begin
                    m_valid_next     = 1'b1;
                    m_beat_next.keep = keep_reg;
                    m_beat_next.store_full = 1'b0;
                    if (keep_reg) begin
                        if (count_reg < CNT_W'(MAX_BOXES)) begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            m_beat_next.store_full = 1'b1;
                        end
                    end
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= STEP_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            keep_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            keep_reg    <= keep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_beat_reg   <= m_beat_next;
        cand_reg     <= cand_next;
        cols_reg     <= cols_next;
        rows_reg     <= rows_next;
        area_reg     <= area_next;
        inter_reg    <= inter_next;
        skip_reg     <= skip_next;
        skip_mul_reg <= skip_mul_next;
    end

`ifndef SYNTHESIS
    // The survivor count never passes the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("survivor count exceeds store depth");

    // The scan index never runs past the survivor count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == STEP_LOOP) |-> (idx_reg <= count_reg))
        else $error("scan index past survivor count");

    // A full store is only reported for a kept box.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_beat_reg.store_full && !m_beat_reg.keep))
        else $error("store_full without keep");

    // An accepted beat always starts the survivor scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (upc_reg == STEP_LOOP))
        else $error("accepted beat did not start the scan");
`endif

endmodule

[sv/gobs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gobs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sim/greedy_overlap_box_suppression_test.sv]
// ----------------------------------------------------------------------------
// Greedy overlap box suppression: testbench
// Sends boxes in lists: directed cases for edges, threshold, touching and
// zero-area boxes and a full store, then random lists. Each verdict beat is
// checked against an in-bench predictor while both channels idle at random.
// ----------------------------------------------------------------------------
module greedy_overlap_box_suppression_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gobs_pkg::*;

    localparam int  MAX_BOXES   = MAX_BOXES_DEF;
    localparam int  COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int  TAIL_CYCLES = 4 * MAX_BOXES + 20;
    localparam int  CYCLE_LIMIT = 1_500_000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_beat  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_beat;

    box_t      survivors[MAX_BOXES];
    int        n_survivors = 0;
    out_beat_t verdicts_due[$];
    int        fail_count  = 0;
    int        burst_left  = 0;
    bit        sender_idles = 1'b1;
    int        cycles      = 0;
    logic [10:0] ready_phase = '0;

    greedy_overlap_box_suppression #(
        .MAX_BOXES(MAX_BOXES)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_beat (s_beat),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_beat (m_beat)
    );

    always #10 aclk = ~aclk;

    function automatic bit overlap_suppresses(input box_t s, input box_t c);
        int     s_r, s_b, c_r, c_b;
        longint area, inter;
        s_r  = int'(s.x) + int'(s.w);
        s_b  = int'(s.y) + int'(s.h);
        c_r  = int'(c.x) + int'(c.w);
        c_b  = int'(c.y) + int'(c.h);
        area = longint'(s.w) * longint'(s.h);
        if (area == 0) begin
            return 1'b0;
        end
        if (int'(s.x) > c_r || int'(s.y) > c_b || s_r < int'(c.x) || s_b < int'(c.y)) begin
            return 1'b0;
        end
        inter = longint'((s_r < c_r ? s_r : c_r) - (s.x > c.x ? int'(s.x) : int'(c.x)))
              * longint'((s_b < c_b ? s_b : c_b) - (s.y > c.y ? int'(s.y) : int'(c.y)));
        return (5 * inter >= 2 * area);
    endfunction

    function automatic out_beat_t judge_box(input in_beat_t b);
        box_t      c;
        out_beat_t v;
        c = '{b.box_x, b.box_y, b.box_width, b.box_height};
        v.keep       = 1'b1;
        v.store_full = 1'b0;
        if (b.first_of_list) begin
            n_survivors = 0;
        end
        for (int i = 0; i < n_survivors; i++) begin
            if (overlap_suppresses(survivors[i], c)) begin
                v.keep = 1'b0;
                break;
            end
        end
        if (v.keep) begin
            if (n_survivors < MAX_BOXES) begin
                survivors[n_survivors] = c;
                n_survivors++;
            end else begin
                v.store_full = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic coord_t to_coord(input int v);
        return (v < 0) ? coord_t'(0) : (v > COORD_MAX) ? coord_t'(COORD_MAX) : coord_t'(v);
    endfunction

    function automatic in_beat_t mk(input int x, input int y, input int w, input int h,
                                    input bit first);
        in_beat_t b;
        b.box_x         = to_coord(x);
        b.box_y         = to_coord(y);
        b.box_width     = to_coord(w);
        b.box_height    = to_coord(h);
        b.first_of_list = first;
        return b;
    endfunction

    // In dense lists most later boxes land near a survivor so the overlap test
    // is exercised close to its threshold; sparse lists aim to fill the store.
    function automatic in_beat_t random_box(input bit first, input bit sparse);
        int   pick, dx, dy, x, y, w, h, lim;
        box_t base;
        pick = $urandom_range(0, 99);
        if (!first && !sparse && n_survivors > 0 && pick < 55) begin
            base = survivors[$urandom_range(0, n_survivors - 1)];
            dx = int'(base.w) / 2 + 1;
            dy = int'(base.h) / 2 + 1;
            x = int'(base.x) + int'($urandom_range(0, 2 * dx)) - dx;
            y = int'(base.y) + int'($urandom_range(0, 2 * dy)) - dy;
            w = int'(base.w) + int'($urandom_range(0, 2 * dx)) - dx;
            h = int'(base.h) + int'($urandom_range(0, 2 * dy)) - dy;
        end else if (sparse || pick < 85) begin
            lim = sparse ? 40 : 300;
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
            w = $urandom_range(1, lim);
            h = $urandom_range(1, lim);
        end else if (pick < 95) begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
            w = $urandom_range(0, COORD_MAX);
            h = $urandom_range(0, COORD_MAX);
        end else begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
            w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 500);
            h = (w == 0) ? $urandom_range(0, 500) : 0;
        end
        return mk(x, y, w, h, first);
    endfunction

    task automatic send_box(input in_beat_t b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_idles ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_beat  <= b;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        verdicts_due.insert(verdicts_due.size(), judge_box(b));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        send_box(mk(0, 0, 0, 0, 1'b1));
        send_box(mk(0, 0, 0, 0, 1'b0));
        send_box(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        send_box(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        send_box(mk(0, 0, COORD_MAX, COORD_MAX, 1'b0));
        send_box(mk(2048, 2048, 2047, 2047, 1'b0));
    endtask

    task automatic test_threshold();
        send_box(mk(100, 100, 10, 10, 1'b1));
        send_box(mk(100, 100, 4, 10, 1'b0));
        send_box(mk(100, 100, 3, 10, 1'b0));
        send_box(mk(105, 100, 20, 10, 1'b0));
        send_box(mk(500, 500, 100, 100, 1'b1));
        send_box(mk(540, 540, 10, 10, 1'b0));
        send_box(mk(400, 400, 300, 300, 1'b0));
    endtask

    task automatic test_touching();
        send_box(mk(200, 200, 10, 10, 1'b1));
        send_box(mk(210, 200, 10, 10, 1'b0));
        send_box(mk(200, 210, 10, 10, 1'b0));
        send_box(mk(190, 190, 10, 10, 1'b0));
        send_box(mk(1000, 1000, 5, 5, 1'b0));
    endtask

    task automatic test_zero_area();
        send_box(mk(300, 300, 0, 50, 1'b1));
        send_box(mk(300, 300, 50, 50, 1'b0));
        send_box(mk(300, 300, 50, 50, 1'b0));
        send_box(mk(300, 300, 50, 0, 1'b1));
        send_box(mk(290, 290, 80, 80, 1'b0));
    endtask

    task automatic test_store_full();
        for (int i = 0; i < MAX_BOXES + 2; i++) begin
            send_box(mk((i % 9) * 400, (i / 9) * 400, 10, 10, i == 0));
        end
        send_box(mk(0, 0, 10, 10, 1'b0));
        wait_drained();
        send_box(mk(0, 0, 10, 10, 1'b1));
    endtask

    task automatic test_random_lists(input int n_items);
        int sent, len, lists;
        bit sparse;
        sent  = 0;
        lists = 0;
        while (sent < n_items) begin
            sparse = ($urandom_range(0, 7) == 0);
            len = sparse ? $urandom_range(60, 80) : $urandom_range(1, 30);
            sender_idles = (lists % 4 != 3);
            for (int pos = 0; pos < len; pos++) begin
                send_box(random_box(pos == 0 || $urandom_range(0, 49) == 0, sparse));
            end
            sent += len;
            lists++;
            if (lists % 10 == 0) begin
                wait_drained();
            end
        end
        sender_idles = 1'b1;
    endtask

    always @(posedge aclk) begin
        ready_phase <= ready_phase + 1'b1;
        case (ready_phase[10:9])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_ready <= (ready_phase[2:0] == 3'd0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin : check_verdicts
        out_beat_t due;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual keep=%0b store_full=%0b",
                         $time, m_beat.keep, m_beat.store_full);
                fail_count++;
            end else begin
                due = verdicts_due.pop_front();
                if (m_beat.keep !== due.keep) begin
                    $display("%0t: keep expected %0b actual %0b",
                             $time, due.keep, m_beat.keep);
                    fail_count++;
                end
                if (m_beat.store_full !== due.store_full) begin
                    $display("%0t: store_full expected %0b actual %0b",
                             $time, due.store_full, m_beat.store_full);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $time, verdicts_due.size());
            $display("greedy_overlap_box_suppression: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_threshold();
        test_touching();
        test_zero_area();
        test_store_full();
        test_random_lists(1050);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("greedy_overlap_box_suppression: match");
        end else begin
            $display("greedy_overlap_box_suppression: mismatch");
        end
        $finish;
    end

endmodule
